FILE: rtl/bloq_pkg.sv
// ----------------------------------------------------------------------------
// bloq_pkg
// Shared types, codes and defaults for the bounded list with overflow queue.
// ----------------------------------------------------------------------------
package bloq_pkg;

	localparam int PLATE_W = 56;
	localparam int CNT_W   = 5;
	localparam int POS_W   = 4;

	localparam int LIST_DEPTH_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = 5'd16;

	// action codes
	localparam logic [1:0] ACT_ARRIVE = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	// status codes
	localparam logic [2:0] ST_ENTERED = 3'd0;
	localparam logic [2:0] ST_QUEUED  = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_REMOVED = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;
	localparam logic [2:0] ST_BADPOS  = 3'd5;
	localparam logic [2:0] ST_READ    = 3'd6;

	typedef struct packed {
		logic [1:0]         action;
		logic [PLATE_W-1:0] plate;
		logic [POS_W-1:0]   position;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [PLATE_W-1:0] plate_out;
		logic [CNT_W-1:0]   onboard_count;
		logic [CNT_W-1:0]   waiting_count;
	} out_t;

endpackage

FILE: rtl/bloq_ram.sv
// ----------------------------------------------------------------------------
// bloq_ram
// Single-clock memory, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bloq_ram
	import bloq_pkg::*;
#(
	parameter int DEPTH = LIST_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      wr_addr,
	input  logic [PLATE_W-1:0] wr_data,
	input  logic               re,
	input  logic [AW-1:0]      rd_addr,
	output logic [PLATE_W-1:0] rd_data
);

	logic [PLATE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/bounded_list_with_overflow_queue_top.sv
// ----------------------------------------------------------------------------
// bounded_list_with_overflow_queue_top
// Ordered list of identifiers with an overflow FIFO, both held in memories.
// ----------------------------------------------------------------------------
// Arrive, empty-list and bad-position items give their result in the cycle
//   after acceptance; a read passes through S_RD; a removal passes through
//   S_REM_HEAD, S_SHIFT (once per entry behind the position), S_REFILL and,
//   when the queue head refills, S_REFILL_WR. One item at a time; the removal
//   shift through the list memory (one entry per cycle on its single write
//   port) sets the worst case. The receiver cannot stall a result.
// Reset: counts, pointers, control and capacity (16) clear at once; the
//   memories are not cleared and are read only where written.
module bounded_list_with_overflow_queue_top
	import bloq_pkg::*;
#(
	parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              command,
	output logic             done,
	output out_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int LAW = $clog2(LIST_DEPTH);
	localparam int LCW = $clog2(LIST_DEPTH + 1);
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_RD        = 3'd1;
	localparam logic [2:0] S_REM_HEAD  = 3'd2;
	localparam logic [2:0] S_SHIFT     = 3'd3;
	localparam logic [2:0] S_REFILL    = 3'd4;
	localparam logic [2:0] S_REFILL_WR = 3'd5;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] capacity_q;
	logic [LCW-1:0]   list_count_q;
	logic [QCW-1:0]   q_count_q;
	logic [QAW-1:0]   q_head_q;
	logic [QAW-1:0]   q_tail_q;
	logic [LAW-1:0]   idx_q;
	logic [PLATE_W-1:0] pout_q;
	logic             done_q;
	out_t             result_q;

	// list memory ports
	logic               l_we;
	logic [LAW-1:0]     l_wa;
	logic [PLATE_W-1:0] l_wd;
	logic               l_re;
	logic [LAW-1:0]     l_ra;
	logic [PLATE_W-1:0] l_rd;

	// queue memory ports
	logic               q_we;
	logic [PLATE_W-1:0] q_rd;

	logic [LCW-1:0] limit;
	logic           accept;
	logic           list_room;
	logic           q_full;
	logic           pos_ok;
	logic           shift_more;
	logic           refill_go;

	// Effective limit: capacity clipped to the list depth.
	assign limit = (32'(capacity_q) > LIST_DEPTH) ? LCW'(LIST_DEPTH) : LCW'(capacity_q);

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign result    = result_q;

	assign list_room  = 32'(list_count_q) < 32'(limit);
	assign q_full     = 32'(q_count_q) == QUEUE_DEPTH;
	assign pos_ok     = 32'(command.position) < 32'(list_count_q);
	// Another entry lies beyond the one just read for the shift.
	assign shift_more = (32'(idx_q) + 2) < 32'(list_count_q);
	// In S_REFILL the decrement is not yet visible, so the new count is list_count_q - 1.
	assign refill_go  = (q_count_q != '0) && ((32'(list_count_q) - 1) < 32'(limit));

	// Memory port control: in the shift, each entry is read in the cycle before its write.
	always_comb begin
		l_we = 1'b0;
		l_wa = LAW'(list_count_q);
		l_wd = command.plate;
		l_re = 1'b0;
		l_ra = LAW'(command.position);
		q_we = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// arriving item goes straight to the list tail when there is room
				l_we = accept && (command.action == ACT_ARRIVE) && list_room;
				l_re = accept;
				q_we = accept && (command.action == ACT_ARRIVE) && !list_room && !q_full;
			end
			S_REM_HEAD: begin
				l_re = 1'b1;
				l_ra = LAW'(32'(idx_q) + 1);
			end
			S_SHIFT: begin
				// close the gap: entry idx+1 (read last cycle) moves to idx
				l_we = 1'b1;
				l_wa = idx_q;
				l_wd = l_rd;
				l_re = shift_more;
				l_ra = LAW'(32'(idx_q) + 2);
			end
			S_REFILL_WR: begin
				// queue head lands on the list tail
				l_we = 1'b1;
				l_wa = LAW'(list_count_q);
				l_wd = q_rd;
			end
			default: begin
			end
		endcase
	end

	bloq_ram #(
		.DEPTH(LIST_DEPTH)
	) u_list_ram (
		.clk     (clk),
		.we      (l_we),
		.wr_addr (l_wa),
		.wr_data (l_wd),
		.re      (l_re),
		.rd_addr (l_ra),
		.rd_data (l_rd)
	);

	bloq_ram #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.we      (q_we),
		.wr_addr (q_tail_q),
		.wr_data (command.plate),
		.re      (state_q == S_REFILL),
		.rd_addr (q_head_q),
		.rd_data (q_rd)
	);

	// Configuration: capacity only, written while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Sequencer, counts, pointers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			list_count_q <= '0;
			q_count_q    <= '0;
			q_head_q     <= '0;
			q_tail_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command.action == ACT_ARRIVE) begin
							done_q <= 1'b1;
							if (list_room) begin
								list_count_q <= list_count_q + 1'b1;
							end else if (!q_full) begin
								q_tail_q  <= (q_tail_q == QAW'(QUEUE_DEPTH - 1)) ?
									'0 : q_tail_q + 1'b1;
								q_count_q <= q_count_q + 1'b1;
							end
						end else if (list_count_q == '0) begin
							done_q <= 1'b1;
						end else if (command.action != ACT_READ &&
								command.action != ACT_REMOVE) begin
							done_q <= 1'b1;
						end else if (!pos_ok) begin
							done_q <= 1'b1;
						end else if (command.action == ACT_READ) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_REM_HEAD;
						end
					end
				end
				S_RD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REM_HEAD: begin
					// shift only when an entry follows the removed one
					state_q <= ((32'(idx_q) + 1) < 32'(list_count_q)) ? S_SHIFT : S_REFILL;
				end
				S_SHIFT: begin
					if (!shift_more) begin
						state_q <= S_REFILL;
					end
				end
				S_REFILL: begin
					list_count_q <= list_count_q - 1'b1;
					if (refill_go) begin
						state_q <= S_REFILL_WR;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_REFILL_WR: begin
					list_count_q <= list_count_q + 1'b1;
					q_head_q     <= (q_head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + 1'b1;
					q_count_q    <= q_count_q - 1'b1;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: index, removed identifier, result fields.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				idx_q <= LAW'(command.position);
				result_q.plate_out <= '0;
				result_q.onboard_count <= CNT_W'(list_count_q);
				result_q.waiting_count <= CNT_W'(q_count_q);
				if (command.action == ACT_ARRIVE) begin
					if (list_room) begin
						result_q.status        <= ST_ENTERED;
						result_q.onboard_count <= CNT_W'(32'(list_count_q) + 1);
					end else if (!q_full) begin
						result_q.status        <= ST_QUEUED;
						result_q.waiting_count <= CNT_W'(32'(q_count_q) + 1);
					end else begin
						result_q.status <= ST_DROPPED;
					end
				end else if (list_count_q == '0) begin
					result_q.status <= ST_EMPTY;
				end else begin
					result_q.status <= ST_BADPOS;
				end
			end
			S_RD: begin
				result_q.status    <= ST_READ;
				result_q.plate_out <= l_rd;
			end
			S_REM_HEAD: begin
				pout_q <= l_rd;
			end
			S_SHIFT: begin
				idx_q <= idx_q + 1'b1;
			end
			S_REFILL: begin
				result_q.status        <= ST_REMOVED;
				result_q.plate_out     <= pout_q;
				result_q.onboard_count <= CNT_W'(32'(list_count_q) - 1);
				result_q.waiting_count <= CNT_W'(q_count_q);
			end
			S_REFILL_WR: begin
				result_q.onboard_count <= CNT_W'(32'(list_count_q) + 1);
				result_q.waiting_count <= CNT_W'(32'(q_count_q) - 1);
			end
			default: begin
			end
		endcase
	end

	// An empty queue has its pointers together.
	a_queue_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count_q == '0) |-> (q_head_q == q_tail_q))
		else $error("queue empty but head and tail differ");

	// The list never holds more than its depth.
	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(list_count_q) <= LIST_DEPTH)
		else $error("list count beyond depth");

	// An arrival answers in the next cycle and leaves the block idle.
	a_arrive_one: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command.action == ACT_ARRIVE) |=> (done && !busy))
		else $error("arrival did not answer in one cycle");

	// A removal finishes through the refill decision, never straight from a shift.
	a_remove_path: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_REMOVED) |->
		($past(state_q) == S_REFILL || $past(state_q) == S_REFILL_WR))
		else $error("removal result from wrong state");

	// An item that entered the list leaves it nonempty.
	a_entered_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_ENTERED) |-> (result.onboard_count != '0))
		else $error("entered item but list empty");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded list with overflow queue. A short table
// of directed items opens the run: empty list, bad positions, the spare action,
// lowered capacity and capacity zero. Several random phases with their own
// capacity settings and action mixes follow. Every accepted item goes through
// a local model of the list and the queue, and each strobed result is checked
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
	import bloq_pkg::*;

	// action 3 has no meaning in the block; it still answers with a status
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam logic [PLATE_W-1:0] PLATE_ONES = '1;

	// capacity settings for the first random phases; later phases pick at random
	localparam logic [CNT_W-1:0] CAP_PLAN [6] = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd2, 5'd15};

	localparam int PHASES     = 10;
	localparam int PHASE_ITEMS = 38;

	// one line of the directed table: a capacity write, or an item with an
	// optional expected result typed in by hand
	typedef struct {
		bit               is_cfg;
		logic [CNT_W-1:0] cap;
		in_t              cmd;
		bit               pinned;
		out_t             want;
	} script_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_t              command;
	logic             done;
	out_t             result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	// local copy of the block's state
	logic [PLATE_W-1:0] roster [LIST_DEPTH_DEF];
	int                 roster_count;
	logic [PLATE_W-1:0] backlog [QUEUE_DEPTH_DEF];
	int                 backlog_head;
	int                 backlog_tail;
	int                 backlog_count;
	logic [CNT_W-1:0]   capacity_reg;

	out_t expected_results [$];
	int   fault_count;
	int   burst_left;

	bounded_list_with_overflow_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Work out the result of one item and advance the local state.
	function automatic out_t predict_step(in_t cmd);
		out_t r;
		int   lim;
		int   i;
		r = '0;
		lim = (capacity_reg > LIST_DEPTH_DEF) ? LIST_DEPTH_DEF : int'(capacity_reg);
		if (cmd.action == ACT_ARRIVE) begin
			if (roster_count < lim) begin
				roster[roster_count] = cmd.plate;
				roster_count++;
				r.status = ST_ENTERED;
			end else if (backlog_count < QUEUE_DEPTH_DEF) begin
				backlog[backlog_tail] = cmd.plate;
				backlog_tail = (backlog_tail + 1) % QUEUE_DEPTH_DEF;
				backlog_count++;
				r.status = ST_QUEUED;
			end else begin
				r.status = ST_DROPPED;
			end
		end else if (roster_count == 0) begin
			r.status = ST_EMPTY;
		end else if (cmd.action == ACT_SPARE || cmd.position >= roster_count) begin
			r.status = ST_BADPOS;
		end else if (cmd.action == ACT_READ) begin
			r.plate_out = roster[cmd.position];
			r.status = ST_READ;
		end else begin
			// close the gap, then refill from the queue head if the limit allows
			r.plate_out = roster[cmd.position];
			for (i = cmd.position; i + 1 < roster_count; i++)
				roster[i] = roster[i + 1];
			roster_count--;
			if (backlog_count != 0 && roster_count < lim) begin
				roster[roster_count] = backlog[backlog_head];
				roster_count++;
				backlog_head = (backlog_head + 1) % QUEUE_DEPTH_DEF;
				backlog_count--;
			end
			r.status = ST_REMOVED;
		end
		r.onboard_count = CNT_W'(roster_count);
		r.waiting_count = CNT_W'(backlog_count);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
		fault_count++;
	endtask

	// Present one item from a falling edge and hold it until accepted; record the
	// expected result at the accepting edge. Return on the next falling edge.
	task automatic issue(in_t cmd, bit pinned, out_t want);
		out_t predicted;
		start <= 1'b1;
		command <= cmd;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = predict_step(cmd);
		expected_results.push_back(pinned ? want : predicted);
		@(negedge clk);
	endtask

	// Sender pacing: unless steady, bursts of back-to-back items separated by random gaps.
	task automatic pace(bit steady);
		if (!steady) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = $urandom_range(0, 10);
			end
		end
	endtask

	// Write the capacity only with the block idle: drain every result first.
	task automatic write_capacity(logic [CNT_W-1:0] value);
		start <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		capacity_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker: every strobe must match the oldest expected result.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(result), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.plate_out !== want.plate_out)
					report_mismatch("plate_out", 64'(result.plate_out), 64'(want.plate_out));
				if (result.onboard_count !== want.onboard_count)
					report_mismatch("onboard_count", 64'(result.onboard_count),
						64'(want.onboard_count));
				if (result.waiting_count !== want.waiting_count)
					report_mismatch("waiting_count", 64'(result.waiting_count),
						64'(want.waiting_count));
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		script_row_t script [$];
		script_row_t row;
		in_t         cmd;
		logic [63:0] raw;
		int          phase;
		int          n;
		int          roll;
		int          arrive_pct;
		int          remove_pct;
		int          read_pct;
		bit          steady;
		logic [CNT_W-1:0] cap;

		// drive every input to a known value from time zero
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		roster_count = 0;
		backlog_head = 0;
		backlog_tail = 0;
		backlog_count = 0;
		capacity_reg = CAPACITY_RESET;
		fault_count = 0;
		burst_left = 0;
		foreach (roster[i]) roster[i] = '0;
		foreach (backlog[i]) backlog[i] = '0;

		// Directed table. Reset state first: empty list for every action but arrival.
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd0}, 1'b1,
			out_t'{ST_EMPTY, '0, 5'd0, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_READ, '0, 4'd15}, 1'b1,
			out_t'{ST_EMPTY, '0, 5'd0, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_SPARE, PLATE_ONES, 4'd15}, 1'b1,
			out_t'{ST_EMPTY, '0, 5'd0, 5'd0}});
		// extremes of the identifier, read back, then bad position and spare action
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, PLATE_ONES, 4'd15}, 1'b1,
			out_t'{ST_ENTERED, '0, 5'd1, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, '0, 4'd0}, 1'b1,
			out_t'{ST_ENTERED, '0, 5'd2, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_READ, '0, 4'd0}, 1'b1,
			out_t'{ST_READ, PLATE_ONES, 5'd2, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_READ, '0, 4'd15}, 1'b1,
			out_t'{ST_BADPOS, '0, 5'd2, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_SPARE, '0, 4'd0}, 1'b1,
			out_t'{ST_BADPOS, '0, 5'd2, 5'd0}});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, 56'h0123456789ABCD, 4'd0}, 1'b0, '0});
		// lower capacity below the count: arrivals queue, removals refill only
		// once the count drops below the new limit
		script.push_back('{1'b1, 5'd1, '0, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, 56'hAAAAAAAAAAAAAA, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, 56'h55555555555555, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd1}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd1}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_READ, '0, 4'd0}, 1'b0, '0});
		// capacity zero: nothing enters, removal never refills
		script.push_back('{1'b1, 5'd0, '0, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, 56'h80000000000001, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_READ, '0, 4'd0}, 1'b0, '0});
		// capacity above the list depth acts as the depth; read and remove one past the last entry
		script.push_back('{1'b1, 5'd31, '0, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, 56'h00000000000001, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_ARRIVE, 56'hFEDCBA98765432, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd0}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_READ, '0, 4'd2}, 1'b0, '0});
		script.push_back('{1'b0, '0, in_t'{ACT_REMOVE, '0, 4'd2}, 1'b0, '0});

		// hold reset, then release it on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[k]) begin
			row = script[k];
			if (row.is_cfg) begin
				write_capacity(row.cap);
			end else begin
				issue(row.cmd, row.pinned, row.want);
				pace(1'b0);
			end
		end

		// Random phases: each sets a capacity and an action mix. Arrival-heavy
		// phases fill the list and the queue until items drop; drain phases empty
		// them again. Every fourth phase runs without sender gaps.
		for (phase = 0; phase < PHASES; phase++) begin
			cap = (phase < 6) ? CAP_PLAN[phase] : CNT_W'($urandom_range(0, 31));
			write_capacity(cap);
			steady = (phase % 4 == 1);
			case (phase % 3)
				0: begin
					arrive_pct = 60; remove_pct = 20; read_pct = 12;
				end
				1: begin
					arrive_pct = 40; remove_pct = 30; read_pct = 20;
				end
				default: begin
					arrive_pct = 25; remove_pct = 45; read_pct = 22;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				raw = {$urandom(), $urandom()};
				cmd.plate = raw[PLATE_W-1:0];
				if (roll < arrive_pct)
					cmd.action = ACT_ARRIVE;
				else if (roll < arrive_pct + remove_pct)
					cmd.action = ACT_REMOVE;
				else if (roll < arrive_pct + remove_pct + read_pct)
					cmd.action = ACT_READ;
				else
					cmd.action = ACT_SPARE;
				// mostly hit a live entry; the rest land anywhere, bad ones included
				if (roster_count > 0 && $urandom_range(0, 4) != 0)
					cmd.position = POS_W'($urandom_range(0, roster_count - 1));
				else
					cmd.position = POS_W'($urandom_range(0, 15));
				issue(cmd, 1'b0, '0);
				pace(steady);
			end
		end

		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// allow a full removal latency for any stray result
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
